// ===== rtl/gregorian_days_between_dates_unit_defines.svh =====
// Assertion macros for the date difference unit checker.
`ifndef GREGORIAN_DAYS_BETWEEN_DATES_UNIT_DEFINES_SVH
`define GREGORIAN_DAYS_BETWEEN_DATES_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GDBD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gdbd checker: property failed");

// next-cycle implication, sampled on clk, off during reset
`define GDBD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gdbd checker: property failed");

`endif

// ===== rtl/gdbd_pkg.sv =====
// Shared widths, status codes, calendar tables and pipeline types of the date difference unit.
package gdbd_pkg;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int COUNT_W  = 22;
	localparam int STATUS_W = 2;
	localparam int ORD_W    = 23;
	localparam int LDAYS_W  = 12;
	localparam int DBM_W    = 9;

	// floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT for any 14-bit n
	localparam int RECIP_SHIFT = 20;
	localparam int QUO_W       = 8;
	localparam int PROD_W      = RECIP_SHIFT + QUO_W;
	localparam logic [YEAR_W-1:0] RECIP_100 = YEAR_W'(10486);

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ORDER   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		logic [QUO_W-1:0]   qy;    // y / 100
		logic [QUO_W-1:0]   qp;    // (y - 1) / 100
		logic               fmt_ok;
	} date_s1_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  y;
		logic [DAY_W-1:0]   d;
		logic [LDAYS_W-1:0] ldays;
		logic [DBM_W-1:0]   dbm;
		logic               ok;
	} date_s2_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [DBM_W-1:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/gregorian_days_between_dates_unit.sv =====
// Date difference unit: days between two proleptic Gregorian dates, four-stage pipeline.
//
// Request channel: req_valid / req_stall with the start date (first_*) and the
// end date (last_*). A request is taken at a clock edge with req_valid high and
// req_stall low. Result channel: res_valid / res_stall with day_count and status
// (ok, end before start, invalid date); day_count is 0 unless status is ok and
// saturates at all ones if the span does not fit.
// Pipeline: four register stages, the first loaded on the accepting edge, and the
// result shows from the fourth. Throughput: one request per cycle while req_stall is low.
// The four register stages are: reciprocal multiply for the divisions by 100,
// leap year and range checks, day ordinal sum, subtract and compare.
// Reset clears the stage valid bits; the pipeline is empty and takes a request
// in the first cycle after reset.
// When the receiver stalls, the result stage holds; earlier stages keep moving
// into empty slots, and req_stall rises only once all four stages are full.
module gregorian_days_between_dates_unit #(
	parameter int unsigned MAX_YEAR = gdbd_pkg::MAX_YEAR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [gdbd_pkg::DAY_W-1:0]    first_day,
	input  logic [gdbd_pkg::MONTH_W-1:0]  first_month,
	input  logic [gdbd_pkg::YEAR_W-1:0]   first_year,
	input  logic [gdbd_pkg::DAY_W-1:0]    last_day,
	input  logic [gdbd_pkg::MONTH_W-1:0]  last_month,
	input  logic [gdbd_pkg::YEAR_W-1:0]   last_year,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [gdbd_pkg::COUNT_W-1:0]  day_count,
	output logic [gdbd_pkg::STATUS_W-1:0] status
);
	import gdbd_pkg::*;

	localparam logic [15:0] MAX_YEAR_L = 16'(MAX_YEAR);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic [YEAR_W-1:0]  y_in [2];
	logic [MONTH_W-1:0] m_in [2];
	logic [DAY_W-1:0]   d_in [2];

	date_s1_t date_c1 [2];
	date_s1_t date_s1 [2];
	date_s2_t date_c2 [2];
	date_s2_t date_s2 [2];
	logic [ORD_W-1:0] ord_c3 [2];
	logic [ORD_W-1:0] ord_s3 [2];
	logic ok_s3;

	logic [ORD_W-1:0]    diff_c4;
	logic [COUNT_W-1:0]  count_c4;
	logic [STATUS_W-1:0] status_c4;
	logic [COUNT_W-1:0]  count_s4;
	logic [STATUS_W-1:0] status_s4;

	assign en4 = !v_s4 || !res_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req_stall = !en1;

	assign y_in[0] = first_year;
	assign m_in[0] = first_month;
	assign d_in[0] = first_day;
	assign y_in[1] = last_year;
	assign m_in[1] = last_month;
	assign d_in[1] = last_day;

	// stage 1: divide year and year-1 by 100, check month and year range
	always_comb begin
		logic [PROD_W-1:0] py, pp;
		logic [YEAR_W-1:0] p;
		for (int i = 0; i < 2; i++) begin
			p = y_in[i] - YEAR_W'(1);
			py = PROD_W'(y_in[i]) * PROD_W'(RECIP_100);
			pp = PROD_W'(p) * PROD_W'(RECIP_100);
			date_c1[i].y = y_in[i];
			date_c1[i].m = m_in[i];
			date_c1[i].d = d_in[i];
			date_c1[i].qy = py[PROD_W-1 -: QUO_W];
			date_c1[i].qp = pp[PROD_W-1 -: QUO_W];
			date_c1[i].fmt_ok = (m_in[i] >= MONTH_JAN) && (m_in[i] <= MONTH_DEC) &&
				(16'(y_in[i]) <= MAX_YEAR_L);
		end
	end

	// stage 2: leap year, day range, leap days before the year, month offset
	always_comb begin
		logic century, leap;
		logic [YEAR_W-1:0] p;
		logic [LDAYS_W:0] ld;
		for (int i = 0; i < 2; i++) begin
			century = ((YEAR_W+1)'(date_s1[i].qy) * (YEAR_W+1)'(100)) ==
				(YEAR_W+1)'(date_s1[i].y);
			leap = (date_s1[i].y[1:0] == 2'd0) && (!century || date_s1[i].qy[1:0] == 2'd0);
			p = date_s1[i].y - YEAR_W'(1);
			ld = (LDAYS_W+1)'(p[YEAR_W-1:2]) - (LDAYS_W+1)'(date_s1[i].qp) +
				(LDAYS_W+1)'(date_s1[i].qp[QUO_W-1:2]) + (LDAYS_W+1)'(1);
			date_c2[i].y = date_s1[i].y;
			date_c2[i].d = date_s1[i].d;
			date_c2[i].ldays = (date_s1[i].y != '0) ? ld[LDAYS_W-1:0] : '0;
			date_c2[i].dbm = days_before(date_s1[i].m) +
				DBM_W'((date_s1[i].m > MONTH_FEB) && leap);
			date_c2[i].ok = date_s1[i].fmt_ok && (date_s1[i].d != '0) &&
				(date_s1[i].d <= month_len(date_s1[i].m, leap));
		end
	end

	// stage 3: day ordinal from 1 January of year 0
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			ord_c3[i] = ORD_W'(date_s2[i].y) * ORD_W'(365) + ORD_W'(date_s2[i].ldays) +
				ORD_W'(date_s2[i].dbm) + ORD_W'(date_s2[i].d) - ORD_W'(1);
		end
	end

	// stage 4: validity and order check, difference, saturation
	always_comb begin
		diff_c4 = ord_s3[1] - ord_s3[0];
		if (!ok_s3) begin
			count_c4 = '0;
			status_c4 = STATUS_INVALID;
		end else if (ord_s3[1] < ord_s3[0]) begin
			count_c4 = '0;
			status_c4 = STATUS_ORDER;
		end else begin
			count_c4 = diff_c4[ORD_W-1:COUNT_W] != '0 ? '1 : diff_c4[COUNT_W-1:0];
			status_c4 = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) date_s1 <= date_c1;
		if (en2) date_s2 <= date_c2;
		if (en3) begin
			ord_s3 <= ord_c3;
			ok_s3 <= date_s2[0].ok && date_s2[1].ok;
		end
		if (en4) begin
			count_s4 <= count_c4;
			status_s4 <= status_c4;
		end
	end

	assign res_valid = v_s4;
	assign day_count = count_s4;
	assign status = status_s4;

endmodule

// ===== rtl/gdbd_checker.sv =====
// Port-level checker for the date difference unit, bound to that module.
`include "gregorian_days_between_dates_unit_defines.svh"

module gdbd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic [gdbd_pkg::COUNT_W-1:0]  day_count,
	input logic [gdbd_pkg::STATUS_W-1:0] status
);
	import gdbd_pkg::*;

	`GDBD_ASSERT_IMP(a_err_zero, res_valid && status != STATUS_OK, day_count == '0)
	`GDBD_ASSERT_IMP(a_latency, $rose(res_valid), $past(req_valid && !req_stall, 4))
	`GDBD_ASSERT_IMP(a_stall_full, req_stall, res_valid && res_stall)
	`GDBD_ASSERT_NXT(a_hold, res_valid && res_stall, res_valid && $stable(day_count) && $stable(status))

endmodule

bind gregorian_days_between_dates_unit gdbd_checker u_gdbd_checker (.*);
